[sv/fts_pkg.sv]
// fts_pkg: shared types and constants for the foot trajectory stepper.
// Holds operation and register codes, FSM types, widths and reset values.
// No dependencies.
`timescale 1ns / 1ps

package fts_pkg;

	// Fixed datapath widths
	localparam int LW = 36;            // linear lane accumulator width
	localparam int WW = 54;            // Bezier accumulator width
	localparam int NLANE = 5;          // number of serial multiply lanes

	// Lanes of the first serial multiply pass
	localparam int LN_X = 0;
	localparam int LN_Y = 1;
	localparam int LN_Z = 2;
	localparam int LN_A = 3;
	localparam int LN_B = 4;

	localparam logic [16:0] PHASE_ONE = 17'd65536;
	localparam logic [4:0]  MUL_LAST  = 5'd16;
	localparam logic [3:0]  DIV_LAST  = 4'd15;

	// Operation codes
	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_TARGET = 2'd1;
	localparam logic [1:0] OP_HOME   = 2'd2;

	// Configuration register indexes
	localparam logic [2:0] REG_HOME_X  = 3'd0;
	localparam logic [2:0] REG_HOME_Y  = 3'd1;
	localparam logic [2:0] REG_HOME_Z  = 3'd2;
	localparam logic [2:0] REG_TICK    = 3'd3;
	localparam logic [2:0] REG_THRESH  = 3'd4;
	localparam logic [2:0] REG_MIN_DUR = 3'd5;

	// Register reset values
	localparam logic [16:0] HOME_X_RST  = 17'd0;
	localparam logic [16:0] HOME_Y_RST  = 17'd655;
	localparam logic [16:0] HOME_Z_RST  = 17'd17367;
	localparam logic [15:0] TICK_RST    = 16'd655;
	localparam logic [15:0] THRESH_RST  = 16'd328;
	localparam logic [15:0] MIN_DUR_RST = 16'd655;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_PREP,
		ST_MUL1,
		ST_MID,
		ST_MID2,
		ST_MUL2,
		ST_ZSET,
		ST_FIN
	} state_t;

	typedef enum logic [1:0] {
		DV_IDLE,
		DV_CHECK,
		DV_RUN
	} div_state_t;

	typedef struct packed {
		logic        done;
		logic [16:0] step;
	} div_stat_t;

endpackage

[sv/fts_divider.sv]
// fts_divider: radix-2 restoring divider for the phase step.
// Produces min(floor(65536*tick/divisor), 65536), one quotient bit a cycle.
// Depends on fts_pkg.
`timescale 1ns / 1ps

module fts_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [15:0]       tick,
	input  logic [19:0]       divisor,
	output fts_pkg::div_stat_t stat
);
	import fts_pkg::*;

	div_state_t  st_q, st_d;
	logic [19:0] dvs_q;
	logic [19:0] rem_q;
	logic [15:0] quo_q;
	logic [3:0]  cnt_q;
	logic        done_q;
	logic [16:0] step_q;

	logic [20:0] rem2;
	logic [20:0] rem_sub;
	logic        ge;
	logic        sat;
	logic        last;

	assign rem2    = {rem_q, 1'b0};
	assign rem_sub = rem2 - {1'b0, dvs_q};
	assign ge      = rem2 >= {1'b0, dvs_q};
	// Quotient of at least one whole phase
	assign sat     = {4'b0, tick} >= dvs_q;
	assign last    = cnt_q == DIV_LAST;

	always_comb begin
		st_d = st_q;
		case (st_q)
			DV_IDLE:  if (start) st_d = DV_CHECK;
			DV_CHECK: st_d = sat ? DV_IDLE : DV_RUN;
			DV_RUN:   if (last) st_d = DV_IDLE;
			default:  st_d = DV_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= DV_IDLE;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			done_q <= (st_q == DV_CHECK && sat) || (st_q == DV_RUN && last);
			if (st_q == DV_RUN) cnt_q <= cnt_q + 4'd1;
			else                cnt_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			DV_IDLE: begin
				if (start) dvs_q <= divisor;
			end
			DV_CHECK: begin
				rem_q <= {4'b0, tick};
				quo_q <= '0;
				if (sat) step_q <= PHASE_ONE;
			end
			DV_RUN: begin
				rem_q <= ge ? rem_sub[19:0] : rem2[19:0];
				quo_q <= {quo_q[14:0], ge};
				if (last) step_q <= {1'b0, quo_q[14:0], ge};
			end
			default: ;
		endcase
	end

	assign stat.done = done_q;
	assign stat.step = step_q;

endmodule

[sv/foot_trajectory_stepper.sv]
// foot_trajectory_stepper: top level of the per-leg foot trajectory generator.
// Holds the handshakes, registers, sequencer and bit-serial multiply lanes.
// Depends on fts_pkg and fts_divider.
`timescale 1ns / 1ps

// Usage
//   Request channel: in_valid / in_stall with operation, target_x/y/z,
//   move_duration and lift_height. A request is taken when in_valid is high
//   and in_stall is low. in_stall is high while a request is in work.
//   Result channel: out_valid / out_stall with pos_x/y/z, phase_now, in_swing
//   and move_done. Every request yields exactly one result.
//   Configuration: cfg_we writes cfg_data into register cfg_index; write only
//   while no request is in work. Unknown indexes are dropped.
// Sequencing, from the request that is taken to its result:
//   home and unused code go straight to the final state.
//   set target runs the 16-step serial divider, which it skips when the step saturates.
//   tick runs one pass for linear z and a second pass for Bezier z, on
//   the bit-serial multiplier that scans the 17 phase bits once per pass.
//   Requests are handled one at a time: a new one is taken only once the last has left the final state.
// The result register frees the request side: a new request is taken while a
// result waits, and if the receiver still stalls when the next result is ready,
// the block holds in its final state until the result register drains.
// Reset puts the foot at home with the move done and restores the registers.

module foot_trajectory_stepper (
	input  logic               clk,
	input  logic               arst_n,
	// request channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         operation,
	input  logic signed [16:0] target_x,
	input  logic signed [16:0] target_y,
	input  logic signed [16:0] target_z,
	input  logic [19:0]        move_duration,
	input  logic [15:0]        lift_height,
	// result channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [16:0] pos_x,
	output logic signed [16:0] pos_y,
	output logic signed [17:0] pos_z,
	output logic [16:0]        phase_now,
	output logic               in_swing,
	output logic               move_done,
	// configuration
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [16:0]        cfg_data
);
	import fts_pkg::*;

	function automatic logic signed [LW-1:0] sxl17(input logic [16:0] v);
		return {{(LW-17){v[16]}}, v};
	endfunction

	function automatic logic signed [LW-1:0] sxl18(input logic [17:0] v);
		return {{(LW-18){v[17]}}, v};
	endfunction

	function automatic logic signed [WW-1:0] sxw(input logic [LW-1:0] v);
		return {{(WW-LW){v[LW-1]}}, v};
	endfunction

	// Configuration registers
	logic signed [16:0] home_x_q, home_y_q, home_z_q;
	logic [15:0]        tick_q, thresh_q, min_dur_q;

	// Trajectory state
	logic signed [16:0] start_q [3];
	logic signed [16:0] goal_q  [3];
	logic signed [16:0] cur_x_q, cur_y_q;
	logic signed [17:0] cur_z_q;
	logic [16:0]        progress_q;
	logic [16:0]        step_q;
	logic [15:0]        lift_q;
	logic               swing_q;

	// Sequencer
	state_t             state_q, state_d;
	logic [4:0]         cnt_q;

	// Serial multiply datapath
	logic [16:0]        mult_q;
	logic signed [17:0] m_q;
	logic signed [LW-1:0] opnd_q [NLANE];
	logic signed [LW-1:0] acc_q  [NLANE];
	logic signed [WW-1:0] bop_q;
	logic signed [WW-1:0] bacc_q;

	// Result register
	logic               out_valid_q;
	logic signed [16:0] pos_x_q, pos_y_q;
	logic signed [17:0] pos_z_q;
	logic [16:0]        phase_q;
	logic               swing_out_q;

	// Combinational helpers
	logic               accept;
	logic               out_load;
	logic               div_start;
	div_stat_t          div_st;
	logic [15:0]        min_eff;
	logic [19:0]        dur_eff;
	logic [17:0]        prog_sum;
	logic [16:0]        prog_next;
	logic signed [16:0] zmin;
	logic signed [17:0] m_next;
	logic signed [16:0] cur_z_clamp;
	logic signed [LW-1:0] x_new, y_new, z_new;
	logic signed [LW-1:0] a_full, b_full;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = state_q != ST_IDLE;
	assign out_load  = (state_q == ST_FIN) && (!out_valid_q || !out_stall);
	assign div_start = accept && (operation == OP_TARGET);

	// A zero minimum acts as one; the divisor is never below it
	assign min_eff = (min_dur_q == 16'd0) ? 16'd1 : min_dur_q;
	assign dur_eff = (move_duration < {4'b0, min_eff}) ? {4'b0, min_eff} : move_duration;

	// Advance the phase, saturating at one whole phase
	assign prog_sum  = {1'b0, progress_q} + {1'b0, step_q};
	assign prog_next = (progress_q >= PHASE_ONE) ? progress_q :
	                   (prog_sum > {1'b0, PHASE_ONE}) ? PHASE_ONE : prog_sum[16:0];

	// Bezier control point: below the lower of start and goal by the lift
	assign zmin   = (start_q[2] < goal_q[2]) ? start_q[2] : goal_q[2];
	assign m_next = {zmin[16], zmin} - {2'b0, lift_q};

	// Clamp current z into the 17-bit start range
	assign cur_z_clamp = (cur_z_q[17] != cur_z_q[16]) ?
	                     (cur_z_q[17] ? -17'sd65536 : 17'sd65535) : cur_z_q[16:0];

	// Linear results: start + floor(delta*p / 2^16)
	assign x_new = sxl17(start_q[0]) + (acc_q[LN_X] >>> 16);
	assign y_new = sxl17(start_q[1]) + (acc_q[LN_Y] >>> 16);
	assign z_new = sxl17(start_q[2]) + (acc_q[LN_Z] >>> 16);

	// Bezier in de Casteljau form, all products by p:
	//   A = s*2^16 + p*(m-s), B = m*2^16 + p*(g-m), sum = A*2^16 + p*(B-A)
	assign a_full = (sxl17(start_q[2]) <<< 16) + acc_q[LN_A];
	assign b_full = (sxl18(m_q) <<< 16) + acc_q[LN_B];

	fts_divider u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.tick    (tick_q),
		.divisor (dur_eff),
		.stat    (div_st)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (operation)
						OP_TICK:   state_d = ST_PREP;
						OP_TARGET: state_d = ST_DIV;
						default:   state_d = ST_FIN;
					endcase
				end
			end
			ST_DIV:  if (div_st.done) state_d = ST_FIN;
			ST_PREP: state_d = ST_MUL1;
			ST_MUL1: if (cnt_q == MUL_LAST) state_d = ST_MID;
			ST_MID:  state_d = swing_q ? ST_MID2 : ST_FIN;
			ST_MID2: state_d = ST_MUL2;
			ST_MUL2: if (cnt_q == MUL_LAST) state_d = ST_ZSET;
			ST_ZSET: state_d = ST_FIN;
			ST_FIN:  if (out_load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Control and trajectory state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			home_x_q    <= HOME_X_RST;
			home_y_q    <= HOME_Y_RST;
			home_z_q    <= HOME_Z_RST;
			tick_q      <= TICK_RST;
			thresh_q    <= THRESH_RST;
			min_dur_q   <= MIN_DUR_RST;
			start_q[0]  <= HOME_X_RST;
			start_q[1]  <= HOME_Y_RST;
			start_q[2]  <= HOME_Z_RST;
			goal_q[0]   <= HOME_X_RST;
			goal_q[1]   <= HOME_Y_RST;
			goal_q[2]   <= HOME_Z_RST;
			cur_x_q     <= HOME_X_RST;
			cur_y_q     <= HOME_Y_RST;
			cur_z_q     <= {HOME_Z_RST[16], HOME_Z_RST};
			progress_q  <= PHASE_ONE;
			step_q      <= '0;
			lift_q      <= '0;
			swing_q     <= 1'b0;
		end else begin
			state_q <= state_d;

			if (out_load)       out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;

			if (state_q == ST_MUL1 || state_q == ST_MUL2) cnt_q <= cnt_q + 5'd1;
			else                                          cnt_q <= '0;

			if (cfg_we) begin
				case (cfg_index)
					REG_HOME_X:  home_x_q  <= cfg_data;
					REG_HOME_Y:  home_y_q  <= cfg_data;
					REG_HOME_Z:  home_z_q  <= cfg_data;
					REG_TICK:    tick_q    <= cfg_data[15:0];
					REG_THRESH:  thresh_q  <= cfg_data[15:0];
					REG_MIN_DUR: min_dur_q <= cfg_data[15:0];
					default: ;
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (operation)
							OP_TICK: begin
								progress_q <= prog_next;
							end
							OP_TARGET: begin
								// Capture the current position as the new start
								start_q[0] <= cur_x_q;
								start_q[1] <= cur_y_q;
								start_q[2] <= cur_z_clamp;
								goal_q[0]  <= target_x;
								goal_q[1]  <= target_y;
								goal_q[2]  <= target_z;
								progress_q <= '0;
								lift_q     <= lift_height;
								swing_q    <= lift_height > thresh_q;
							end
							OP_HOME: begin
								start_q[0] <= home_x_q;
								start_q[1] <= home_y_q;
								start_q[2] <= home_z_q;
								goal_q[0]  <= home_x_q;
								goal_q[1]  <= home_y_q;
								goal_q[2]  <= home_z_q;
								cur_x_q    <= home_x_q;
								cur_y_q    <= home_y_q;
								cur_z_q    <= {home_z_q[16], home_z_q};
								progress_q <= PHASE_ONE;
								step_q     <= '0;
								swing_q    <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				ST_DIV: begin
					if (div_st.done) step_q <= div_st.step;
				end
				ST_MID: begin
					cur_x_q <= x_new[16:0];
					cur_y_q <= y_new[16:0];
					if (!swing_q) cur_z_q <= z_new[17:0];
				end
				ST_ZSET: begin
					cur_z_q <= bacc_q[49:32];
				end
				default: ;
			endcase
		end
	end

	// Serial multiply lanes and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) m_q <= m_next;
			end
			ST_PREP: begin
				opnd_q[LN_X] <= sxl17(goal_q[0]) - sxl17(start_q[0]);
				opnd_q[LN_Y] <= sxl17(goal_q[1]) - sxl17(start_q[1]);
				opnd_q[LN_Z] <= sxl17(goal_q[2]) - sxl17(start_q[2]);
				opnd_q[LN_A] <= sxl18(m_q) - sxl17(start_q[2]);
				opnd_q[LN_B] <= sxl17(goal_q[2]) - sxl18(m_q);
				for (int l = 0; l < NLANE; l++) begin
					acc_q[l] <= '0;
				end
				mult_q <= progress_q;
			end
			ST_MUL1: begin
				// Scan one phase bit, LSB first, across all lanes
				for (int l = 0; l < NLANE; l++) begin
					if (mult_q[0]) acc_q[l] <= acc_q[l] + opnd_q[l];
					opnd_q[l] <= opnd_q[l] <<< 1;
				end
				mult_q <= mult_q >> 1;
			end
			ST_MID: begin
				bacc_q <= sxw(a_full) <<< 16;
				bop_q  <= sxw(b_full);
			end
			ST_MID2: begin
				// B - A; bacc holds A*2^16 with clear low bits
				bop_q  <= bop_q - (bacc_q >>> 16);
				mult_q <= progress_q;
			end
			ST_MUL2: begin
				if (mult_q[0]) bacc_q <= bacc_q + bop_q;
				bop_q  <= bop_q <<< 1;
				mult_q <= mult_q >> 1;
			end
			default: ;
		endcase

		if (out_load) begin
			pos_x_q     <= cur_x_q;
			pos_y_q     <= cur_y_q;
			pos_z_q     <= cur_z_q;
			phase_q     <= progress_q;
			swing_out_q <= swing_q;
		end
	end

	assign out_valid = out_valid_q;
	assign pos_x     = pos_x_q;
	assign pos_y     = pos_y_q;
	assign pos_z     = pos_z_q;
	assign phase_now = phase_q;
	assign in_swing  = swing_out_q;
	assign move_done = phase_q >= PHASE_ONE;

`ifndef SYNTHESIS
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		progress_q <= PHASE_ONE)
		else $error("phase beyond one whole phase");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |-> state_q == ST_DIV)
		else $error("divider finished outside of a set target");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_FIN)
		else $error("result loaded outside of the final state");

	a_mul1_to_mid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL1 && cnt_q == MUL_LAST) |=> state_q == ST_MID)
		else $error("multiply pass did not end after the last phase bit");
`endif

endmodule

[dv/foot_trajectory_stepper_tb.sv]
// foot_trajectory_stepper_tb: self-checking bench for the foot trajectory stepper.
// Drives targets, ticks and home requests under several register settings and
// checks each result against an in-bench model or a hand-written pose. Depends on fts_pkg and the RTL.
`timescale 1ns / 1ps

module foot_trajectory_stepper_tb;
	import fts_pkg::*;

	// Codes the package does not name
	localparam logic [1:0] OP_NOP    = 2'd3;   // unused operation, reports state
	localparam logic [2:0] REG_SPARE = 3'd7;   // unmapped register index

	localparam longint PHASE_END      = 65536;
	localparam int     ITEMS_PER_SET  = 132;
	localparam int     LAST_SET       = 6;
	localparam int     WATCHDOG_LIMIT = 2000;
	localparam int     SETTLE_CYCLES  = 60;
	localparam int     REPORT_LIMIT   = 10;

	typedef struct packed {
		logic [1:0]         op;
		logic signed [16:0] tx;
		logic signed [16:0] ty;
		logic signed [16:0] tz;
		logic [19:0]        dur;
		logic [15:0]        lift;
	} request_t;

	typedef struct packed {
		logic signed [16:0] x;
		logic signed [16:0] y;
		logic signed [17:0] z;
		logic [16:0]        phase;
		logic               swing;
		logic               done;
	} foot_result_t;

	typedef struct packed {
		request_t     req;
		logic         typed;   // use the hand-written pose instead of the model
		foot_result_t want;
	} plan_row_t;

	// ---------------------------------------------------------------------
	// DUT signals; every input has a known value from time zero
	// ---------------------------------------------------------------------
	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         operation = OP_TICK;
	logic signed [16:0] target_x = '0;
	logic signed [16:0] target_y = '0;
	logic signed [16:0] target_z = '0;
	logic [19:0]        move_duration = '0;
	logic [15:0]        lift_height = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [16:0] pos_x;
	logic signed [16:0] pos_y;
	logic signed [17:0] pos_z;
	logic [16:0]        phase_now;
	logic               in_swing;
	logic               move_done;
	logic               cfg_we = 1'b0;
	logic [2:0]         cfg_index = REG_HOME_X;
	logic [16:0]        cfg_data = '0;

	foot_trajectory_stepper DUT (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ---------------------------------------------------------------------
	// Trajectory model: register copies and per-leg state
	// ---------------------------------------------------------------------
	longint home_pos [3] = '{longint'($signed(HOME_X_RST)), longint'($signed(HOME_Y_RST)),
		longint'($signed(HOME_Z_RST))};
	longint tick_len  = TICK_RST;
	longint thresh    = THRESH_RST;
	longint min_dur   = MIN_DUR_RST;

	longint start_p [3];
	longint goal_p  [3];
	longint cur_p   [3];
	longint progress;
	longint phase_step;
	longint lift_held = 0;
	bit     swing_on;

	foot_result_t pending_poses [$];   // predicted poses not yet returned

	bit idling_on = 1'b1;
	int requests_sent = 0;
	int results_seen = 0;
	int swing_results = 0;
	int done_results = 0;
	int mismatches = 0;
	int settings_used = 1;

	function automatic void go_home_state();
		for (int i = 0; i < 3; i++) begin
			start_p[i] = home_pos[i];
			goal_p[i] = home_pos[i];
			cur_p[i] = home_pos[i];
		end
		progress = PHASE_END;
		phase_step = 0;
		swing_on = 1'b0;
	endfunction

	// Apply one request to the model and return the pose it reports.
	function automatic foot_result_t advance_foot(input request_t r);
		foot_result_t res;
		longint span, q, c, p, u, s, g, m;
		case (r.op)
			OP_TARGET: begin
				// Clamp the duration from below; a zero minimum acts as one
				span = (min_dur == 0) ? 1 : min_dur;
				q = r.dur;
				if (q < span)
					q = span;
				q = (tick_len * PHASE_END) / q;
				phase_step = (q > PHASE_END) ? PHASE_END : q;
				// Start from where the foot is, z squeezed back into 17 bits
				for (int i = 0; i < 3; i++) begin
					c = cur_p[i];
					if (c > 65535)
						c = 65535;
					if (c < -65536)
						c = -65536;
					start_p[i] = c;
				end
				goal_p[0] = longint'(r.tx);
				goal_p[1] = longint'(r.ty);
				goal_p[2] = longint'(r.tz);
				progress = 0;
				lift_held = r.lift;
				swing_on = lift_held > thresh;
			end
			OP_HOME: go_home_state();
			OP_TICK: begin
				if (progress < PHASE_END) begin
					progress = progress + phase_step;
					if (progress > PHASE_END)
						progress = PHASE_END;
				end
				p = progress;
				u = PHASE_END - p;
				for (int i = 0; i < 2; i++)
					cur_p[i] = start_p[i] + (((goal_p[i] - start_p[i]) * p) >>> 16);
				s = start_p[2];
				g = goal_p[2];
				if (swing_on) begin
					m = ((s < g) ? s : g) - lift_held;
					cur_p[2] = (u * u * s + 2 * u * p * m + p * p * g) >>> 32;
				end else begin
					cur_p[2] = s + (((g - s) * p) >>> 16);
				end
			end
			default: ;
		endcase
		res.x = cur_p[0][16:0];
		res.y = cur_p[1][16:0];
		res.z = cur_p[2][17:0];
		res.phase = progress[16:0];
		res.swing = swing_on;
		res.done = progress >= PHASE_END;
		return res;
	endfunction

	function automatic string show_pose(input foot_result_t r);
		return $sformatf("x=%0d y=%0d z=%0d phase=%0d swing=%0b done=%0b",
			r.x, r.y, r.z, r.phase, r.swing, r.done);
	endfunction

	// ---------------------------------------------------------------------
	// Request side; every task here is entered and left at a falling edge
	// ---------------------------------------------------------------------
	task automatic send_request(input request_t r, input logic typed, input foot_result_t want);
		foot_result_t predicted;
		// Drop valid for a random gap now and then, never in the same step as raising it
		if (idling_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= r.op;
		target_x <= r.tx;
		target_y <= r.ty;
		target_z <= r.tz;
		move_duration <= r.dur;
		lift_height <= r.lift;
		// Hold the request until an edge takes it
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predicted = advance_foot(r);
		pending_poses = {pending_poses, (typed ? want : predicted)};
		requests_sent++;
		@(negedge clk);
	endtask

	// Let every outstanding result come back, then let the block sit idle before going on.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_poses.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [16:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		case (idx)
			REG_HOME_X:  home_pos[0] = longint'($signed(val));
			REG_HOME_Y:  home_pos[1] = longint'($signed(val));
			REG_HOME_Z:  home_pos[2] = longint'($signed(val));
			REG_TICK:    tick_len = val[15:0];
			REG_THRESH:  thresh = val[15:0];
			REG_MIN_DUR: min_dur = val[15:0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(input logic [16:0] hx, input logic [16:0] hy,
		input logic [16:0] hz, input logic [16:0] tick, input logic [16:0] th,
		input logic [16:0] mind);
		write_reg(REG_HOME_X, hx);
		write_reg(REG_HOME_Y, hy);
		write_reg(REG_HOME_Z, hz);
		write_reg(REG_TICK, tick);
		write_reg(REG_THRESH, th);
		write_reg(REG_MIN_DUR, mind);
		// An unmapped index must leave every register alone
		write_reg(REG_SPARE, 17'($urandom()));
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	function automatic request_t random_request(input logic [1:0] op);
		request_t r;
		r.op = op;
		r.tx = 17'($urandom());
		r.ty = 17'($urandom());
		r.tz = 17'($urandom());
		r.dur = 20'($urandom());
		r.lift = 16'($urandom());
		if (op == OP_TARGET) begin
			// Mostly short moves so that a few ticks carry them to the goal
			if ($urandom_range(0, 3) != 0)
				r.dur = 20'($urandom_range(0, 6 * tick_len + 6));
			case ($urandom_range(0, 3))
				0: r.lift = '0;
				1: r.lift = 16'(thresh + $urandom_range(0, 2) - 1);   // around the threshold
				default: ;
			endcase
			if ($urandom_range(0, 7) == 0) begin
				r.tx = $urandom_range(0, 1) ? 17'h10000 : 17'h0FFFF;
				r.ty = $urandom_range(0, 1) ? 17'h10000 : 17'h0FFFF;
				r.tz = $urandom_range(0, 1) ? 17'h10000 : 17'h0FFFF;
			end
		end
		return r;
	endfunction

	// Mostly whole moves (a target, then a run of ticks), the rest single random requests.
	task automatic run_random(input int count);
		int left;
		request_t r;
		left = count;
		while (left > 0) begin
			if ($urandom_range(0, 9) < 8) begin
				send_request(random_request(OP_TARGET), 1'b0, '0);
				left--;
				repeat ($urandom_range(1, 10)) begin
					r = random_request(($urandom_range(0, 19) == 0) ? OP_NOP : OP_TICK);
					send_request(r, 1'b0, '0);
					if (r.op != OP_NOP)
						left--;
				end
			end else begin
				r = random_request(2'($urandom_range(0, 3)));
				send_request(r, 1'b0, '0);
				if (r.op != OP_NOP)
					left--;
			end
		end
	endtask

	// ---------------------------------------------------------------------
	// Directed plan under reset settings: home (0, 655, 17367), tick 655,
	// threshold 328, minimum duration 655
	// ---------------------------------------------------------------------
	plan_row_t directed_plan [23] = '{
		// home, a tick and the unused code all report the home pose, move done
		'{'{OP_HOME, 0, 0, 0, 0, 0}, 1'b1, '{0, 655, 17367, PHASE_ONE, 1'b0, 1'b1}},
		'{'{OP_TICK, 0, 0, 0, 0, 0}, 1'b1, '{0, 655, 17367, PHASE_ONE, 1'b0, 1'b1}},
		'{'{OP_NOP, -1, -1, -1, 20'hFFFFF, 16'hFFFF}, 1'b1,
			'{0, 655, 17367, PHASE_ONE, 1'b0, 1'b1}},
		// zero duration clamps to the minimum: one tick finishes, full lift swings
		'{'{OP_TARGET, 65535, -65536, -65536, 0, 16'hFFFF}, 1'b1,
			'{0, 655, 17367, 0, 1'b1, 1'b0}},
		'{'{OP_TICK, 0, 0, 0, 0, 0}, 1'b1, '{65535, -65536, -65536, PHASE_ONE, 1'b1, 1'b1}},
		// longest duration, no lift: tiny step, linear z
		'{'{OP_TARGET, -65536, 65535, 65535, 20'hFFFFF, 0}, 1'b1,
			'{65535, -65536, -65536, 0, 1'b0, 1'b0}},
		'{'{OP_TICK, 0, 0, 0, 0, 0}, 1'b0, '0},
		'{'{OP_TICK, 0, 0, 0, 0, 0}, 1'b0, '0},
		'{'{OP_TICK, 0, 0, 0, 0, 0}, 1'b0, '0},
		// retarget mid-move, lift one above the threshold
		'{'{OP_TARGET, 1000, -2000, 30000, 1310, 329}, 1'b0, '0},
		'{'{OP_TICK, 0, 0, 0, 0, 0}, 1'b0, '0},
		'{'{OP_TICK, 0, 0, 0, 0, 0}, 1'b0, '0},
		// lift equal to the threshold stays linear; home aborts the move
		'{'{OP_TARGET, -30000, 40000, -5000, 655, 328}, 1'b0, '0},
		'{'{OP_HOME, 0, 0, 0, 0, 0}, 1'b1, '{0, 655, 17367, PHASE_ONE, 1'b0, 1'b1}},
		// swing to the low corner in two half steps
		'{'{OP_TARGET, -65536, -65536, -65536, 1310, 16'hFFFF}, 1'b0, '0},
		'{'{OP_TICK, 0, 0, 0, 0, 0}, 1'b0, '0},
		'{'{OP_TICK, 0, 0, 0, 0, 0}, 1'b0, '0},
		// swing in place from the corner: z dips below the 17 bit range
		'{'{OP_TARGET, -65536, -65536, -65536, 1310, 16'hFFFF}, 1'b0, '0},
		'{'{OP_TICK, 0, 0, 0, 0, 0}, 1'b0, '0},
		// a new start clamps that z back into range
		'{'{OP_TARGET, 0, 0, 0, 655, 0}, 1'b0, '0},
		'{'{OP_TICK, 0, 0, 0, 0, 0}, 1'b0, '0},
		'{'{OP_TICK, 0, 0, 0, 0, 0}, 1'b0, '0},
		'{'{OP_NOP, 0, 0, 0, 0, 0}, 1'b0, '0}
	};

	// ---------------------------------------------------------------------
	// Stimulus sequence
	// ---------------------------------------------------------------------
	initial begin : stimulus
		// Hold reset, then release it away from the rising edge
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		go_home_state();
		@(negedge clk);

		foreach (directed_plan[i])
			send_request(directed_plan[i].req, directed_plan[i].typed, directed_plan[i].want);
		run_random(ITEMS_PER_SET);
		drain_results();

		for (int set = 1; set <= LAST_SET; set++) begin
			case (set)
				// lowest corner: smallest home, tick and minimum, any lift swings
				1: apply_settings(17'h10000, 17'h10000, 17'h10000, 17'd1, 17'd0, 17'd1);
				// highest corner: a duration at the minimum saturates the step, no lift swings
				2: apply_settings(17'h0FFFF, 17'h0FFFF, 17'h0FFFF, 17'h0FFFF, 17'h0FFFF,
					17'h0FFFF);
				// zero tick length freezes moves; zero minimum acts as one
				3: apply_settings(17'($urandom()), 17'($urandom()), 17'($urandom()), 17'd0,
					17'($urandom()), 17'd0);
				4: apply_settings(17'($urandom()), 17'($urandom()), 17'($urandom()),
					17'($urandom()), 17'($urandom()), 17'd0);
				default: apply_settings(17'($urandom()), 17'($urandom()), 17'($urandom()),
					17'($urandom()), 17'($urandom()), 17'($urandom()));
			endcase
			// Run the final set at full rate on both sides
			if (set == LAST_SET)
				idling_on = 1'b0;
			run_random(ITEMS_PER_SET);
			drain_results();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("%0d requests under %0d register settings; %0d results checked",
			requests_sent, settings_used, results_seen);
		$display("%0d results in swing, %0d with the move complete, %0d mismatches",
			swing_results, done_results, mismatches);
		if (mismatches == 0 && pending_poses.size() == 0)
			$display("foot_trajectory_stepper_tb passed");
		else
			$display("foot_trajectory_stepper_tb failed");
		$finish;
	end

	// ---------------------------------------------------------------------
	// Result side: random stall bursts, changed only at the falling edge
	// ---------------------------------------------------------------------
	always begin : result_backpressure
		@(negedge clk);
		if (idling_on && $urandom_range(0, 9) == 0) begin
			out_stall <= 1'b1;
			repeat ($urandom_range(1, 19)) @(negedge clk);
			out_stall <= 1'b0;
		end
	end

	// Compare every taken result with the oldest predicted pose.
	always @(posedge clk) begin : result_check
		foot_result_t seen;
		foot_result_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			seen = '{pos_x, pos_y, pos_z, phase_now, in_swing, move_done};
			results_seen++;
			if (seen.swing)
				swing_results++;
			if (seen.done)
				done_results++;
			if (pending_poses.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("result %0d with nothing pending: %s", results_seen,
						show_pose(seen));
			end else begin
				want = pending_poses.pop_front();
				if (seen.x !== want.x || seen.y !== want.y || seen.z !== want.z ||
					seen.phase !== want.phase || seen.swing !== want.swing ||
					seen.done !== want.done) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("result %0d: expected %s, got %s", results_seen,
							show_pose(want), show_pose(seen));
				end
			end
		end
	end

	// End the run when neither channel has moved for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("no request or result taken for %0d cycles, %0d results pending",
			quiet, pending_poses.size());
		$display("foot_trajectory_stepper_tb failed");
		$finish;
	end

endmodule
